// File: src/dmxtx_pkg.sv
`default_nettype none

package dmxtx_pkg;

    // slots sent after the start code in each frame
    localparam int unsigned SLOT_COUNT = 512;
    // channels held in the store, addressed 1..NUM_CHANNELS
    localparam int unsigned NUM_CHANNELS = 512;
    localparam int unsigned CH_IDX_W = $clog2(NUM_CHANNELS);

    localparam int unsigned BREAK_W = 18;
    localparam int unsigned MARK_W  = 8;
    localparam int unsigned STEP_W  = 8;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned ADDR_W  = 10;
    localparam int unsigned SLOT_W  = 10;
    localparam int unsigned BIT_W   = 3;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // register indexes (byte address divided by four)
    localparam logic [1:0] REG_BREAK_TICKS = 2'd0;
    localparam logic [1:0] REG_MARK_TICKS  = 2'd1;
    localparam logic [1:0] REG_RAMP_STEP   = 2'd2;

    localparam logic [BREAK_W-1:0] BREAK_TICKS_RST = BREAK_W'(250);
    localparam logic [MARK_W-1:0]  MARK_TICKS_RST  = MARK_W'(3);
    localparam logic [STEP_W-1:0]  RAMP_STEP_RST   = STEP_W'(3);

    // store contents after the clearing pass
    localparam logic [DATA_W-1:0] CH2_RST = DATA_W'(50);
    localparam logic [DATA_W-1:0] CH3_RST = DATA_W'(100);

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic              line_level;
        logic [SLOT_W-1:0] slot_index;
        logic              frame_start;
    } res_t;

endpackage

`default_nettype wire

// File: src/dmx512_frame_transmitter_unit.sv
// dmx512 frame transmitter: one line level per tick item, one result item per input item
// result: each item is registered, and waits in the skid stage while the output is stalled
// throughput: one item per cycle while s_ready is high, bounded by the single-pass state update and output register
// reset: synchronous, active low; registers return to defaults and the channel store is
// cleared by a pass (one entry per cycle) during which s_ready is low
// configuration writes are taken at any time, including during the clearing pass
`default_nettype none

module dmx512_frame_transmitter_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dmxtx_pkg::PADDR_W-1:0] paddr,
    input  wire logic [dmxtx_pkg::PDATA_W-1:0] pwdata,
    output logic      [dmxtx_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    // input items
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_cmd,
    input  wire logic [dmxtx_pkg::ADDR_W-1:0]  s_slot_addr,
    input  wire logic [dmxtx_pkg::DATA_W-1:0]  s_slot_data,
    // result items
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_line_level,
    output logic      [dmxtx_pkg::SLOT_W-1:0]  m_slot_index,
    output logic                               m_frame_start
);

    typedef enum logic [1:0] {
        PH_BREAK,
        PH_MARK,
        PH_START,
        PH_DATA
    } phase_t;

    localparam int unsigned BW = dmxtx_pkg::BREAK_W;
    localparam int unsigned MW = dmxtx_pkg::MARK_W;
    localparam int unsigned SW = dmxtx_pkg::STEP_W;
    localparam int unsigned DW = dmxtx_pkg::DATA_W;
    localparam int unsigned AW = dmxtx_pkg::ADDR_W;
    localparam int unsigned LW = dmxtx_pkg::SLOT_W;
    localparam int unsigned IW = dmxtx_pkg::CH_IDX_W;
    localparam int unsigned XW = dmxtx_pkg::BIT_W;

    // configuration registers
    logic [BW-1:0] break_ticks_reg;
    logic [MW-1:0] mark_ticks_reg;
    logic [SW-1:0] ramp_step_reg;
    logic          cfg_wr;

    // frame sequencer state
    phase_t        phase_reg,      phase_next;
    logic [BW-1:0] tick_reg,       tick_next;
    logic [XW-1:0] bit_reg,        bit_next;
    logic [LW-1:0] slot_cnt_reg,   slot_cnt_next;
    logic [DW-1:0] shift_reg,      shift_next;
    logic          ramp_down_reg,  ramp_down_next;
    logic          held_level_reg, held_level_next;
    logic [LW-1:0] held_slot_reg,  held_slot_next;
    // channel 1 lives in a register so the ramp needs no memory read-modify-write
    logic [DW-1:0] ch1_reg,        ch1_next;

    // clearing pass after reset
    logic          clr_active_reg, clr_active_next;
    logic [IW-1:0] clr_idx_reg,    clr_idx_next;

    // result register and skid stage
    logic                 out_valid_reg,  out_valid_next;
    dmxtx_pkg::res_t      out_data_reg,   out_data_next;
    logic                 skid_valid_reg, skid_valid_next;
    dmxtx_pkg::res_t      skid_data_reg,  skid_data_next;

    // channel store: entry k-1 holds channel k (entry 0 unused, channel 1 is ch1_reg)
    logic [DW-1:0] chan_mem [dmxtx_pkg::NUM_CHANNELS];
    logic [DW-1:0] rd_data_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;

    logic            acc;
    logic            pop;
    dmxtx_pkg::res_t res;
    logic [BW-1:0]   tick_inc;
    logic [DW:0]     ramp_sum;
    logic [DW-1:0]   ramp_val;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign s_ready = !skid_valid_reg && !clr_active_reg;
    assign acc     = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    assign m_valid       = out_valid_reg;
    assign m_line_level  = out_data_reg.line_level;
    assign m_slot_index  = out_data_reg.slot_index;
    assign m_frame_start = out_data_reg.frame_start;

    // register read-back
    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            dmxtx_pkg::REG_BREAK_TICKS: prdata = dmxtx_pkg::PDATA_W'(break_ticks_reg);
            dmxtx_pkg::REG_MARK_TICKS:  prdata = dmxtx_pkg::PDATA_W'(mark_ticks_reg);
            dmxtx_pkg::REG_RAMP_STEP:   prdata = dmxtx_pkg::PDATA_W'(ramp_step_reg);
            default:                    prdata = '0;
        endcase
    end

    // channel 1 ramp: clamp to 0..255, direction flips at either end
    always_comb begin
        if (ramp_down_reg) begin
            ramp_sum = {1'b0, ch1_reg} - {1'b0, ramp_step_reg};
            ramp_val = (ch1_reg >= ramp_step_reg) ? ramp_sum[DW-1:0] : '0;
        end else begin
            ramp_sum = {1'b0, ch1_reg} + {1'b0, ramp_step_reg};
            ramp_val = ramp_sum[DW] ? '1 : ramp_sum[DW-1:0];
        end
    end

    assign tick_inc = tick_reg + BW'(1);

    // sequencer next state, store write port and result
    always_comb begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        bit_next        = bit_reg;
        slot_cnt_next   = slot_cnt_reg;
        shift_next      = shift_reg;
        ramp_down_next  = ramp_down_reg;
        held_level_next = held_level_reg;
        held_slot_next  = held_slot_reg;
        ch1_next        = ch1_reg;
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        mem_we          = 1'b0;
        mem_waddr       = clr_idx_reg;
        mem_wdata       = '0;

        // write items repeat the held level and slot
        res.line_level  = held_level_reg;
        res.slot_index  = held_slot_reg;
        res.frame_start = 1'b0;

        if (clr_active_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            if (clr_idx_reg == IW'(1)) begin
                mem_wdata = dmxtx_pkg::CH2_RST;
            end else if (clr_idx_reg == IW'(2)) begin
                mem_wdata = dmxtx_pkg::CH3_RST;
            end else begin
                mem_wdata = '0;
            end
            clr_idx_next = clr_idx_reg + IW'(1);
            if (clr_idx_reg == IW'(dmxtx_pkg::NUM_CHANNELS - 1)) begin
                clr_active_next = 1'b0;
            end
        end

        if (acc) begin
            if (s_cmd == dmxtx_pkg::CMD_WRITE) begin
                // out-of-range channel numbers are dropped
                if (s_slot_addr == AW'(1)) begin
                    ch1_next = s_slot_data;
                end else if (s_slot_addr >= AW'(2) &&
                             s_slot_addr <= AW'(dmxtx_pkg::NUM_CHANNELS)) begin
                    mem_we    = 1'b1;
                    mem_waddr = IW'(s_slot_addr - AW'(1));
                    mem_wdata = s_slot_data;
                end
            end else begin
                case (phase_reg)
                    PH_BREAK: begin
                        res.line_level  = 1'b0;
                        res.slot_index  = '0;
                        res.frame_start = (tick_reg == '0);
                        // a zero length behaves as one tick
                        if (tick_inc >= break_ticks_reg) begin
                            phase_next    = PH_MARK;
                            tick_next     = '0;
                            slot_cnt_next = '0;
                        end else begin
                            tick_next = tick_inc;
                        end
                    end
                    PH_MARK: begin
                        // slot byte latched on the first mark tick; slot 0 is the start code
                        if (tick_reg == '0) begin
                            if (slot_cnt_reg == '0) begin
                                shift_next = '0;
                            end else if (slot_cnt_reg == LW'(1)) begin
                                shift_next = ch1_reg;
                            end else begin
                                shift_next = rd_data_reg;
                            end
                        end
                        res.line_level = 1'b1;
                        res.slot_index = slot_cnt_reg;
                        if (tick_inc >= BW'(mark_ticks_reg)) begin
                            phase_next = PH_START;
                            tick_next  = '0;
                        end else begin
                            tick_next = tick_inc;
                        end
                    end
                    PH_START: begin
                        res.line_level = 1'b0;
                        res.slot_index = slot_cnt_reg;
                        phase_next     = PH_DATA;
                        bit_next       = '0;
                    end
                    PH_DATA: begin
                        // lsb first
                        res.line_level = shift_reg[0];
                        res.slot_index = slot_cnt_reg;
                        shift_next     = {1'b0, shift_reg[DW-1:1]};
                        if (bit_reg == XW'(DW - 1)) begin
                            bit_next  = '0;
                            tick_next = '0;
                            if (slot_cnt_reg >= LW'(dmxtx_pkg::SLOT_COUNT)) begin
                                // end of frame: ramp channel 1, next break starts at once
                                ch1_next = ramp_val;
                                if (ramp_val == '0 || ramp_val == '1) begin
                                    ramp_down_next = !ramp_down_reg;
                                end
                                phase_next    = PH_BREAK;
                                slot_cnt_next = '0;
                            end else begin
                                slot_cnt_next = slot_cnt_reg + LW'(1);
                                phase_next    = PH_MARK;
                            end
                        end else begin
                            bit_next = bit_reg + XW'(1);
                        end
                    end
                    default: begin
                        phase_next = PH_BREAK;
                    end
                endcase
                held_level_next = res.line_level;
                held_slot_next  = res.slot_index;
            end
        end
    end

    // keep the read register tracking the entry of the slot to be latched next
    assign mem_raddr = IW'(slot_cnt_next - LW'(1));

    // result register with a skid stage behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (acc) begin
            if (!out_valid_reg || pop) begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            break_ticks_reg <= dmxtx_pkg::BREAK_TICKS_RST;
            mark_ticks_reg  <= dmxtx_pkg::MARK_TICKS_RST;
            ramp_step_reg   <= dmxtx_pkg::RAMP_STEP_RST;
            phase_reg       <= PH_BREAK;
            tick_reg        <= '0;
            bit_reg         <= '0;
            slot_cnt_reg    <= '0;
            shift_reg       <= '0;
            ramp_down_reg   <= 1'b0;
            held_level_reg  <= 1'b1;
            held_slot_reg   <= '0;
            ch1_reg         <= '0;
            clr_active_reg  <= 1'b1;
            clr_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    dmxtx_pkg::REG_BREAK_TICKS: break_ticks_reg <= pwdata[BW-1:0];
                    dmxtx_pkg::REG_MARK_TICKS:  mark_ticks_reg  <= pwdata[MW-1:0];
                    dmxtx_pkg::REG_RAMP_STEP:   ramp_step_reg   <= pwdata[SW-1:0];
                    default: ;
                endcase
            end
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            bit_reg        <= bit_next;
            slot_cnt_reg   <= slot_cnt_next;
            shift_reg      <= shift_next;
            ramp_down_reg  <= ramp_down_next;
            held_level_reg <= held_level_next;
            held_slot_reg  <= held_slot_next;
            ch1_reg        <= ch1_next;
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // channel store, with a same-cycle write forwarded into the read register
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            chan_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && mem_waddr == mem_raddr) begin
            rd_data_reg <= mem_wdata;
        end else begin
            rd_data_reg <= chan_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// File: src/dmxtx_checker.sv
`default_nettype none

module dmxtx_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_line_level,
    input wire logic [dmxtx_pkg::SLOT_W-1:0]  m_slot_index,
    input wire logic                          m_frame_start
);

    // a frame start item is always in the break: line low, slot zero
    a_fstart_break: assert property (@(posedge aclk)
        (m_valid && m_frame_start) |-> (!m_line_level && m_slot_index == '0))
        else $error("frame start item outside break");

    // slot index stays within the frame
    a_slot_range: assert property (@(posedge aclk)
        m_valid |-> (m_slot_index <= dmxtx_pkg::SLOT_W'(dmxtx_pkg::SLOT_COUNT)))
        else $error("slot index out of range");

    // store clearing holds off input items right after reset
    a_clear_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !s_ready)
        else $error("input item taken during clearing pass");

    // a stalled result item is held
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_line_level) &&
                                   $stable(m_slot_index) && $stable(m_frame_start)))
        else $error("result item dropped or changed while stalled");

endmodule

bind dmx512_frame_transmitter_unit dmxtx_checker u_dmxtx_checker (.*);

`default_nettype wire

// File: dv/dmx512_frame_transmitter_unit_test.sv
`timescale 1ns / 1ps

module dmx512_frame_transmitter_unit_test;

    // transmitter phases, tracked by the line predictor
    typedef enum logic [1:0] {
        PH_BREAK,
        PH_MARK,
        PH_START,
        PH_DATA
    } line_phase_t;

    typedef struct packed {
        logic                         cmd;
        logic [dmxtx_pkg::ADDR_W-1:0] slot_addr;
        logic [dmxtx_pkg::DATA_W-1:0] slot_data;
    } tx_item_t;

    // clock, reset and every block input start from known values
    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [dmxtx_pkg::PADDR_W-1:0] paddr = '0;
    logic [dmxtx_pkg::PDATA_W-1:0] pwdata = '0;
    logic [dmxtx_pkg::PDATA_W-1:0] prdata;
    logic                          pready;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic                          s_cmd = dmxtx_pkg::CMD_TICK;
    logic [dmxtx_pkg::ADDR_W-1:0]  s_slot_addr = '0;
    logic [dmxtx_pkg::DATA_W-1:0]  s_slot_data = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic                          m_line_level;
    logic [dmxtx_pkg::SLOT_W-1:0]  m_slot_index;
    logic                          m_frame_start;

    // items waiting to be offered, and line levels still owed by the block
    tx_item_t        pending_items[$];
    dmxtx_pkg::res_t owed_levels[$];

    // idle chances in percent, changed between phases
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches = 0;
    // items handed to the sender and result items taken by the receiver
    int unsigned items_queued = 0;
    int unsigned results_seen = 0;

    // own copy of the registers
    logic [dmxtx_pkg::BREAK_W-1:0] brk_len;
    logic [dmxtx_pkg::MARK_W-1:0]  mark_len;
    logic [dmxtx_pkg::STEP_W-1:0]  ramp_len;

    // own copy of the frame state
    logic [dmxtx_pkg::DATA_W-1:0] chan_val [1:dmxtx_pkg::NUM_CHANNELS];
    line_phase_t                  tx_phase;
    int unsigned                  tick_cnt;
    int unsigned                  bit_cnt;
    int unsigned                  slot_cnt;
    logic [dmxtx_pkg::DATA_W-1:0] shift_reg;
    logic                         ramp_dn;
    logic                         held_lvl;
    logic [dmxtx_pkg::SLOT_W-1:0] held_slot;

    dmx512_frame_transmitter_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_slot_addr   (s_slot_addr),
        .s_slot_data   (s_slot_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_line_level  (m_line_level),
        .m_slot_index  (m_slot_index),
        .m_frame_start (m_frame_start)
    );

    always #4 aclk = ~aclk;

    // channel 1 moves one step at the end of every frame, bouncing off 0 and 255
    function automatic void ramp_channel_one();
        int v;
        v = chan_val[1];
        if (ramp_dn) begin
            v = (v >= ramp_len) ? v - ramp_len : 0;
        end else begin
            v = v + ramp_len;
            if (v > 255) v = 255;
        end
        chan_val[1] = dmxtx_pkg::DATA_W'(v);
        if (v == 0 || v == 255) ramp_dn = ~ramp_dn;
    endfunction

    // advance the line by one item and return the level the block must show for it
    function automatic dmxtx_pkg::res_t advance_line(tx_item_t it);
        dmxtx_pkg::res_t r;
        logic lvl;
        logic fst;
        lvl = 1'b1;
        fst = 1'b0;
        if (it.cmd == dmxtx_pkg::CMD_WRITE) begin
            // store update only, time stands still and the last level is repeated
            if (it.slot_addr >= 1 && it.slot_addr <= dmxtx_pkg::NUM_CHANNELS)
                chan_val[it.slot_addr] = it.slot_data;
            r.line_level  = held_lvl;
            r.slot_index  = held_slot;
            r.frame_start = 1'b0;
            return r;
        end
        case (tx_phase)
            PH_BREAK: begin
                lvl = 1'b0;
                held_slot = '0;
                fst = (tick_cnt == 0);
                tick_cnt++;
                // a zero length still gives one tick, since the compare is >=
                if (tick_cnt >= brk_len) begin
                    tx_phase = PH_MARK;
                    tick_cnt = 0;
                    slot_cnt = 0;
                end
            end
            PH_MARK: begin
                // byte latched on the first mark tick, later writes wait a frame
                if (tick_cnt == 0)
                    shift_reg = (slot_cnt == 0) ? '0 : chan_val[slot_cnt];
                lvl = 1'b1;
                held_slot = dmxtx_pkg::SLOT_W'(slot_cnt);
                tick_cnt++;
                if (tick_cnt >= mark_len) begin
                    tx_phase = PH_START;
                    tick_cnt = 0;
                end
            end
            PH_START: begin
                lvl = 1'b0;
                held_slot = dmxtx_pkg::SLOT_W'(slot_cnt);
                tx_phase = PH_DATA;
                bit_cnt = 0;
            end
            default: begin
                lvl = shift_reg[0];
                held_slot = dmxtx_pkg::SLOT_W'(slot_cnt);
                shift_reg = shift_reg >> 1;
                bit_cnt++;
                if (bit_cnt >= 8) begin
                    bit_cnt = 0;
                    tick_cnt = 0;
                    if (slot_cnt >= dmxtx_pkg::SLOT_COUNT) begin
                        ramp_channel_one();
                        tx_phase = PH_BREAK;
                        slot_cnt = 0;
                    end else begin
                        slot_cnt++;
                        tx_phase = PH_MARK;
                    end
                end
            end
        endcase
        held_lvl = lvl;
        r.line_level  = lvl;
        r.slot_index  = held_slot;
        r.frame_start = fst;
        return r;
    endfunction

    // apb write: setup then access, register taken when pready is seen in the access cycle
    task automatic cfg_write(input logic [1:0] idx,
                             input logic [dmxtx_pkg::PDATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            dmxtx_pkg::REG_BREAK_TICKS: brk_len  = value[dmxtx_pkg::BREAK_W-1:0];
            dmxtx_pkg::REG_MARK_TICKS:  mark_len = value[dmxtx_pkg::MARK_W-1:0];
            dmxtx_pkg::REG_RAMP_STEP:   ramp_len = value[dmxtx_pkg::STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_item(input logic cmd, input int unsigned addr,
                              input int unsigned data);
        tx_item_t it;
        it.cmd       = cmd;
        it.slot_addr = dmxtx_pkg::ADDR_W'(addr);
        it.slot_data = dmxtx_pkg::DATA_W'(data);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // mostly ticks; writes lean towards channel 1, out-of-range addresses and extreme values
    task automatic queue_random(input int unsigned count, input int unsigned write_pct);
        int unsigned addr;
        int unsigned data;
        logic        cmd;
        for (int unsigned i = 0; i < count; i++) begin
            case ($urandom_range(7))
                0:       addr = 1;
                1:       addr = $urandom_range(1) ? 0 : $urandom_range(1023, 513);
                default: addr = $urandom_range(dmxtx_pkg::NUM_CHANNELS, 1);
            endcase
            case ($urandom_range(7))
                0:       data = 0;
                1:       data = 255;
                default: data = $urandom_range(255);
            endcase
            cmd = ($urandom_range(99) < write_pct) ? dmxtx_pkg::CMD_WRITE
                                                   : dmxtx_pkg::CMD_TICK;
            queue_item(cmd, addr, data);
        end
    endtask

    // block idle: every queued item answered and taken, then a short settling pause
    task automatic wait_drained();
        do @(posedge aclk);
        while (results_seen < items_queued);
        repeat (4) @(posedge aclk);
    endtask

    task automatic note_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        mismatches++;
    endtask

    // sender: offers queued items, holds each one steady until taken
    always @(posedge aclk) begin : send_p
        tx_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                owed_levels.push_back(advance_line({s_cmd, s_slot_addr, s_slot_data}));
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_items.pop_front();
                    s_valid     <= 1'b1;
                    s_cmd       <= nxt.cmd;
                    s_slot_addr <= nxt.slot_addr;
                    s_slot_data <= nxt.slot_data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker; once in the run it holds off for a long stretch so
    // the output register fills and the block has to stall its input
    always @(posedge aclk) begin : recv_p
        dmxtx_pkg::res_t want;
        int unsigned     hold_left;
        logic            hold_done;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (owed_levels.size() == 0) begin
                    $display("%0t: result item with none expected, %s %0b slot %0d start %0b",
                             $time, "actual level", m_line_level, m_slot_index,
                             m_frame_start);
                    mismatches++;
                end else begin
                    want = owed_levels.pop_front();
                    if (m_line_level !== want.line_level)
                        note_mismatch("line_level", want.line_level, m_line_level);
                    if (m_slot_index !== want.slot_index)
                        note_mismatch("slot_index", want.slot_index, m_slot_index);
                    if (m_frame_start !== want.frame_start)
                        note_mismatch("frame_start", want.frame_start, m_frame_start);
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!hold_done && results_seen >= 1000) begin
                hold_done = 1'b1;
                hold_left = 300;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        // predictor starts where the block lands after reset and its clearing pass
        brk_len  = dmxtx_pkg::BREAK_TICKS_RST;
        mark_len = dmxtx_pkg::MARK_TICKS_RST;
        ramp_len = dmxtx_pkg::RAMP_STEP_RST;
        for (int i = 1; i <= dmxtx_pkg::NUM_CHANNELS; i++) chan_val[i] = '0;
        chan_val[2] = dmxtx_pkg::CH2_RST;
        chan_val[3] = dmxtx_pkg::CH3_RST;
        tx_phase  = PH_BREAK;
        tick_cnt  = 0;
        bit_cnt   = 0;
        slot_cnt  = 0;
        shift_reg = '0;
        ramp_dn   = 1'b0;
        held_lvl  = 1'b1;
        held_slot = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // sender idles a little, receiver a lot
        send_idle_pct = 27;
        recv_idle_pct = 62;

        // short frame so the directed items reach the start code and slot 1
        cfg_write(dmxtx_pkg::REG_BREAK_TICKS, 2);
        cfg_write(dmxtx_pkg::REG_MARK_TICKS, 2);

        // writes before any tick repeat the idle-high level, bad addresses are dropped
        queue_item(dmxtx_pkg::CMD_WRITE, 0, 8'h55);
        queue_item(dmxtx_pkg::CMD_WRITE, 1023, 255);
        queue_item(dmxtx_pkg::CMD_WRITE, 513, 0);
        queue_item(dmxtx_pkg::CMD_WRITE, dmxtx_pkg::NUM_CHANNELS, 255);
        queue_item(dmxtx_pkg::CMD_WRITE, 1, 8'h81);
        // break, then the start code slot
        for (int i = 0; i < 13; i++) begin
            queue_item(dmxtx_pkg::CMD_TICK, $urandom_range(1023), $urandom_range(255));
        end
        // first mark tick of slot 1 latches 0x81, so the next write waits a frame
        queue_item(dmxtx_pkg::CMD_TICK, 0, 0);
        queue_item(dmxtx_pkg::CMD_WRITE, 1, 8'h00);
        for (int i = 0; i < 6; i++) queue_item(dmxtx_pkg::CMD_TICK, 0, 0);
        wait_drained();

        // default timing, random mix
        cfg_write(dmxtx_pkg::REG_BREAK_TICKS, 250);
        cfg_write(dmxtx_pkg::REG_MARK_TICKS, 3);
        cfg_write(dmxtx_pkg::REG_RAMP_STEP, 3);
        queue_random(400, 12);
        wait_drained();

        // now the sender idles a lot and the receiver a little
        send_idle_pct = 62;
        recv_idle_pct = 27;

        // shortest break and mark, largest step
        cfg_write(dmxtx_pkg::REG_BREAK_TICKS, 1);
        cfg_write(dmxtx_pkg::REG_MARK_TICKS, 1);
        cfg_write(dmxtx_pkg::REG_RAMP_STEP, 255);
        queue_random(300, 8);
        wait_drained();

        // zero lengths behave as one
        cfg_write(dmxtx_pkg::REG_BREAK_TICKS, 0);
        cfg_write(dmxtx_pkg::REG_MARK_TICKS, 0);
        cfg_write(dmxtx_pkg::REG_RAMP_STEP, 0);
        queue_random(250, 8);
        wait_drained();

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // longest break and mark
        cfg_write(dmxtx_pkg::REG_BREAK_TICKS, 262143);
        cfg_write(dmxtx_pkg::REG_MARK_TICKS, 255);
        cfg_write(dmxtx_pkg::REG_RAMP_STEP, 1);
        queue_random(150, 5);
        wait_drained();

        // break cut short below the count already reached, long marks
        cfg_write(dmxtx_pkg::REG_BREAK_TICKS, 5);
        queue_random(150, 10);
        wait_drained();

        // random moderate timing
        cfg_write(dmxtx_pkg::REG_BREAK_TICKS, $urandom_range(40, 1));
        cfg_write(dmxtx_pkg::REG_MARK_TICKS, $urandom_range(4, 1));
        cfg_write(dmxtx_pkg::REG_RAMP_STEP, $urandom_range(254, 1));
        queue_random(300, 10);
        wait_drained();

        if (owed_levels.size() != 0)
            $display("%0t: %0d result items never arrived", $time, owed_levels.size());
        if (mismatches == 0 && owed_levels.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // hard stop, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
